[hdl/fmmcs_pkg.sv]
// shared types, constants and helpers for the frame min/max contrast stretch unit
`default_nettype none
package fmmcs_pkg;

  localparam int unsigned FRAME_PIXELS_DEF = 110592;
  localparam int unsigned PIXEL_BITS_DEF   = 16;
  localparam int unsigned IN_PIXEL_BITS    = 16;
  localparam int unsigned DISP_BITS        = 8;
  localparam int unsigned STEP_BITS        = 3;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_READOUT = 1'b1
  } kind_e;

  typedef struct packed {
    logic last;
    logic no_data;
    logic flat;
  } flags_t;

  function automatic int unsigned addr_bits(input int unsigned depth);
    addr_bits = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

[hdl/fmmcs_ram.sv]
// generic simple dual port ram with registered read
`default_nettype none
module fmmcs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = fmmcs_pkg::addr_bits(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[hdl/fmmcs_front.sv]
// front end: accepts transactions, tracks frame statistics, writes pixels, queues readouts
`default_nettype none
module fmmcs_front #(
  parameter int unsigned FRAME_PIXELS = fmmcs_pkg::FRAME_PIXELS_DEF,
  parameter int unsigned PIXEL_BITS   = fmmcs_pkg::PIXEL_BITS_DEF,
  localparam int unsigned AW = fmmcs_pkg::addr_bits(FRAME_PIXELS),
  localparam int unsigned CW = $clog2(FRAME_PIXELS + 1)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  kind_i,
  input  wire logic [fmmcs_pkg::IN_PIXEL_BITS-1:0]   pixel_value_i,
  input  wire logic                                  last_in_frame_i,
  input  wire logic                                  full_i,
  input  wire logic                                  busy_i,
  output logic                                       wr_en_o,
  output logic      [AW-1:0]                         wr_addr_o,
  output logic      [PIXEL_BITS-1:0]                 wr_data_o,
  output logic                                       push_o,
  output logic      [AW-1:0]                         push_addr_o,
  output logic      [PIXEL_BITS-1:0]                 push_min_o,
  output logic      [PIXEL_BITS-1:0]                 push_span_o,
  output fmmcs_pkg::flags_t                          push_flags_o
);

  logic [PIXEL_BITS-1:0] min_q, min_d, max_q, max_d;
  logic [CW-1:0]         count_q, count_d, pos_q, pos_d;
  logic                  complete_q, complete_d;

  logic                  accept, is_load;
  logic [PIXEL_BITS-1:0] pix, base_min, base_max;
  logic [CW-1:0]         base_count, rd_pos, rd_next;
  logic                  rd_last;

  assign is_load    = (fmmcs_pkg::kind_e'(kind_i) == fmmcs_pkg::KIND_LOAD);
  assign in_stall_o = is_load ? busy_i : full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign pix        = pixel_value_i[PIXEL_BITS-1:0];

  assign base_min   = complete_q ? {PIXEL_BITS{1'b1}} : min_q;
  assign base_max   = complete_q ? '0 : max_q;
  assign base_count = complete_q ? '0 : count_q;

  assign rd_pos  = (pos_q >= count_q) ? '0 : pos_q;
  assign rd_next = rd_pos + CW'(1);
  assign rd_last = (rd_next == count_q);

  always_comb begin
    min_d        = min_q;
    max_d        = max_q;
    count_d      = count_q;
    pos_d        = pos_q;
    complete_d   = complete_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = base_count[AW-1:0];
    wr_data_o    = pix;
    push_o       = 1'b0;
    push_addr_o  = rd_pos[AW-1:0];
    push_min_o   = min_q;
    push_span_o  = max_q - min_q;
    push_flags_o = '{last: rd_last, no_data: 1'b0, flat: (max_q <= min_q)};
    if (accept && is_load) begin
      min_d      = base_min;
      max_d      = base_max;
      count_d    = base_count;
      complete_d = 1'b0;
      if (complete_q) begin
        pos_d = '0;
      end
      if (base_count < CW'(FRAME_PIXELS)) begin
        wr_en_o = 1'b1;
        count_d = base_count + CW'(1);
        if (pix < base_min) begin
          min_d = pix;
        end
        if (pix > base_max) begin
          max_d = pix;
        end
      end
      if (last_in_frame_i && (count_d != '0)) begin
        complete_d = 1'b1;
        pos_d      = '0;
      end
    end else if (accept) begin
      push_o = 1'b1;
      if (!complete_q || (count_q == '0)) begin
        push_flags_o = '{last: 1'b0, no_data: 1'b1, flat: 1'b0};
      end else begin
        pos_d = rd_last ? '0 : rd_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q      <= {PIXEL_BITS{1'b1}};
      max_q      <= '0;
      count_q    <= '0;
      pos_q      <= '0;
      complete_q <= 1'b0;
    end else begin
      min_q      <= min_d;
      max_q      <= max_d;
      count_q    <= count_d;
      pos_q      <= pos_d;
      complete_q <= complete_d;
    end
  end

  // a pixel write must never overtake a readout that still has to fetch its pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> !busy_i)
    else $error("pixel write while readouts are pending");

endmodule
`default_nettype wire

[hdl/fmmcs_queue.sv]
// two-entry command queue between front and back
`default_nettype none
module fmmcs_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] head_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PW = $clog2(fmmcs_pkg::QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(fmmcs_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] ent_q [fmmcs_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    cnt_q;

  assign head_o  = ent_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(fmmcs_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      cnt_q <= cnt_q + NW'(push_i) - NW'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

[hdl/fmmcs_back.sv]
// back end: fetches queued pixels, divides by the frame span, holds the result
`default_nettype none
module fmmcs_back #(
  parameter int unsigned FRAME_PIXELS = fmmcs_pkg::FRAME_PIXELS_DEF,
  parameter int unsigned PIXEL_BITS   = fmmcs_pkg::PIXEL_BITS_DEF,
  localparam int unsigned AW = fmmcs_pkg::addr_bits(FRAME_PIXELS)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                empty_i,
  input  wire logic [AW-1:0]                       head_addr_i,
  input  wire logic [PIXEL_BITS-1:0]               head_min_i,
  input  wire logic [PIXEL_BITS-1:0]               head_span_i,
  input  wire fmmcs_pkg::flags_t                   head_flags_i,
  output logic                                     pop_o,
  output logic                                     busy_o,
  output logic                                     rd_en_o,
  output logic      [AW-1:0]                       rd_addr_o,
  input  wire logic [PIXEL_BITS-1:0]               rd_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [fmmcs_pkg::DISP_BITS-1:0]     display_value_o,
  output logic                                     last_of_frame_o,
  output logic                                     no_data_o
);

  localparam int unsigned DB = fmmcs_pkg::DISP_BITS;
  localparam int unsigned NW = PIXEL_BITS + DB;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic   [PIXEL_BITS-1:0]         min_q, min_d, span_q, span_d;
  logic                            flat_q, flat_d, last_q, last_d, nodata_q, nodata_d;
  logic   [NW-1:0]                 rem_q, rem_d, dv_q, dv_d;
  logic   [DB-1:0]                 quo_q, quo_d;
  logic   [fmmcs_pkg::STEP_BITS-1:0] step_q, step_d;

  logic   [PIXEL_BITS-1:0]         diff;
  logic   [NW-1:0]                 num;
  logic                            ge;

  // 255 * (p - min)
  assign diff = rd_data_i - min_q;
  assign num  = {diff, {DB{1'b0}}} - {{DB{1'b0}}, diff};
  assign ge   = (rem_q >= dv_q);

  assign pop_o           = (state_q == ST_IDLE) && !empty_i;
  assign rd_en_o         = pop_o;
  assign rd_addr_o       = head_addr_i;
  assign busy_o          = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign display_value_o = quo_q;
  assign last_of_frame_o = last_q;
  assign no_data_o       = nodata_q;

  always_comb begin
    state_d  = state_q;
    min_d    = min_q;
    span_d   = span_q;
    flat_d   = flat_q;
    last_d   = last_q;
    nodata_d = nodata_q;
    rem_d    = rem_q;
    dv_d     = dv_q;
    quo_d    = quo_q;
    step_d   = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          min_d    = head_min_i;
          span_d   = head_span_i;
          flat_d   = head_flags_i.flat;
          last_d   = head_flags_i.last;
          nodata_d = head_flags_i.no_data;
          quo_d    = '0;
          state_d  = head_flags_i.no_data ? ST_OUT : ST_READ;
        end
      end
      ST_READ: begin
        rem_d   = num;
        dv_d    = {1'b0, span_q, {(DB-1){1'b0}}};
        step_d  = fmmcs_pkg::STEP_BITS'(DB - 1);
        state_d = flat_q ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        if (ge) begin
          rem_d = rem_q - dv_q;
        end
        quo_d  = {quo_q[DB-2:0], ge};
        dv_d   = dv_q >> 1;
        step_d = step_q - fmmcs_pkg::STEP_BITS'(1);
        if (step_q == '0) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    span_q   <= span_d;
    flat_q   <= flat_d;
    last_q   <= last_d;
    nodata_q <= nodata_d;
    rem_q    <= rem_d;
    dv_q     <= dv_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_data_o) |-> (display_value_o == '0) && !last_of_frame_o)
    else $error("no_data result carries pixel fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < {dv_q, 1'b1}))
    else $error("division remainder out of range");

endmodule
`default_nettype wire

[hdl/frame_min_max_contrast_stretch_unit.sv]
// top level of the frame min/max contrast stretch unit
// Load transactions (kind 0) write one pixel each into the frame store and update
// the running minimum and maximum; last_in_frame closes the frame, and a load after that starts
// a new frame. Readout transactions (kind 1) return floor(255*(p-min)/(max-min)) for the next
// stored pixel, 0 for a flat frame, or no_data when no frame is complete. Readouts pass through a
// two-entry queue to a back end that handles one readout at a time: frame store read, 8-step restoring
// divider, result hand-off; a pixel of a flat frame skips the divider, and a no_data result skips
// the read and the divider. A load is held off until all queued readouts are delivered.
// The frame store is not cleared after reset.
`default_nettype none
module frame_min_max_contrast_stretch_unit #(
  parameter int unsigned FRAME_PIXELS = fmmcs_pkg::FRAME_PIXELS_DEF,
  parameter int unsigned PIXEL_BITS   = fmmcs_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                kind_i,
  input  wire logic [fmmcs_pkg::IN_PIXEL_BITS-1:0] pixel_value_i,
  input  wire logic                                last_in_frame_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [fmmcs_pkg::DISP_BITS-1:0]     display_value_o,
  output logic                                     last_of_frame_o,
  output logic                                     no_data_o
);

  localparam int unsigned AW = fmmcs_pkg::addr_bits(FRAME_PIXELS);
  localparam int unsigned FW = $bits(fmmcs_pkg::flags_t);
  localparam int unsigned QW = AW + 2 * PIXEL_BITS + FW;

  logic                    wr_en, rd_en, push, pop, q_empty, q_full, back_busy;
  logic [AW-1:0]           wr_addr, rd_addr, push_addr, head_addr;
  logic [PIXEL_BITS-1:0]   wr_data, rd_data, push_min, push_span, head_min, head_span;
  fmmcs_pkg::flags_t       push_flags, head_flags;
  logic [QW-1:0]           head;

  fmmcs_front #(
    .FRAME_PIXELS(FRAME_PIXELS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .pixel_value_i  (pixel_value_i),
    .last_in_frame_i(last_in_frame_i),
    .full_i         (q_full),
    .busy_i         (back_busy || !q_empty),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .push_o         (push),
    .push_addr_o    (push_addr),
    .push_min_o     (push_min),
    .push_span_o    (push_span),
    .push_flags_o   (push_flags)
  );

  fmmcs_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_addr, push_min, push_span, push_flags}),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  assign {head_addr, head_min, head_span, head_flags} = head;

  fmmcs_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(FRAME_PIXELS)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  fmmcs_back #(
    .FRAME_PIXELS(FRAME_PIXELS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_addr_i    (head_addr),
    .head_min_i     (head_min),
    .head_span_i    (head_span),
    .head_flags_i   (head_flags),
    .pop_o          (pop),
    .busy_o         (back_busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .display_value_o(display_value_o),
    .last_of_frame_o(last_of_frame_o),
    .no_data_o      (no_data_o)
  );

endmodule
`default_nettype wire
